// File: hw/rtl/alu_pkg.sv
// Package with the operation codes shared by the arithmetic unit files.
`timescale 1ns / 1ps
package alu_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} alu_op_t;
endpackage

// File: hw/rtl/alu_stream_if.sv
// Valid/ready channel interface that carries one arithmetic item or result.
`timescale 1ns / 1ps
interface alu_stream_if #(
	parameter int PAYLOAD_BITS = 66
);
	logic valid;
	logic ready;
	logic [PAYLOAD_BITS-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/alu_cell.sv
// One cell of the arithmetic chain: a multiply step and a restoring divide step.
`timescale 1ns / 1ps
module alu_cell #(
	parameter int WORD_BITS = 32,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [1:0]           op_in,
	input  logic [WORD_BITS-1:0] a_in,
	input  logic [WORD_BITS-1:0] b_in,
	input  logic [WORD_BITS-1:0] acc_in,
	input  logic [WORD_BITS-1:0] rem_in,
	output logic                 valid_out,
	output logic [1:0]           op_out,
	output logic [WORD_BITS-1:0] a_out,
	output logic [WORD_BITS-1:0] b_out,
	output logic [WORD_BITS-1:0] acc_out,
	output logic [WORD_BITS-1:0] rem_out
);
	import alu_pkg::*;

	localparam int BIT_IDX = WORD_BITS - 1 - STEP;

	logic [WORD_BITS-1:0] acc_nxt;
	logic [WORD_BITS-1:0] rem_nxt;
	logic [WORD_BITS:0]   shifted;

	// Multiply adds the shifted multiplicand; divide does one restoring step.
	always_comb begin
		acc_nxt = acc_in;
		rem_nxt = rem_in;
		shifted = {rem_in, a_in[BIT_IDX]};
		unique case (alu_op_t'(op_in))
			OP_MUL: begin
				if (b_in[STEP])
					acc_nxt = acc_in + (a_in << STEP);
			end
			OP_DIV: begin
				if (shifted >= {1'b0, b_in}) begin
					rem_nxt = WORD_BITS'(shifted - {1'b0, b_in});
					acc_nxt = acc_in | (WORD_BITS'(1) << BIT_IDX);
				end else begin
					rem_nxt = shifted[WORD_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Hand the item to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_out  <= op_in;
			a_out   <= a_in;
			b_out   <= b_in;
			acc_out <= acc_nxt;
			rem_out <= rem_nxt;
		end
	end
endmodule

// File: hw/rtl/alu_add_sub_mul_div_32.sv
// Top level of the pipelined 32-bit add, subtract, multiply and divide unit.
//
// Channel in_ch carries an item {op, operand_a, operand_b}; out_ch carries
// a result {result_word, divide_by_zero}. Both use valid/ready, and an item
// moves at a clock edge where both are high.
// The unit is a chain of WORD_BITS cells, one multiplier bit and one
// quotient bit per cell, followed by an output register. The first cell
// loads an item at the edge that accepts it; the item passes through each
// cell in turn, and the output register loads the result from the last
// cell, which raises out_ch.valid.
// Unless held, one item is accepted per cycle; the chain is one pipeline.
// When the receiver stalls with the output register full, the whole chain
// holds and in_ch.ready falls in the same cycle. The chain moves again only
// once the output register is free or its result is taken; bubbles inside
// the chain do not let it advance.
// Add and subtract are computed before the first cell and carried down the
// chain. Divide by zero yields all ones and sets the flag.
// Reset clears all valid bits; no item is in flight after reset.
`timescale 1ns / 1ps
module alu_add_sub_mul_div_32 #(
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	alu_stream_if.sink   in_ch,
	alu_stream_if.source out_ch
);
	import alu_pkg::*;

	localparam int N = WORD_BITS;

	logic         vld   [0:N];
	logic [1:0]   opc   [0:N];
	logic [N-1:0] aw    [0:N];
	logic [N-1:0] bw    [0:N];
	logic [N-1:0] accw  [0:N];
	logic [N-1:0] remw  [0:N];
	logic         out_valid_q;
	logic [N-1:0] out_word_q;
	logic         out_dz_q;
	logic         adv;
	logic [N-1:0] res_nxt;
	logic         dz_nxt;
	logic         in_ready;

	// The chain advances when the output register can take what reaches it.
	assign adv = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;
	assign in_ready = adv;

	// Feed the first cell; add and subtract results start in the accumulator.
	always_comb begin
		vld[0] = in_ch.valid && in_ready;
		opc[0] = in_ch.data[2*N+1:2*N];
		aw[0]  = in_ch.data[2*N-1:N];
		bw[0]  = in_ch.data[N-1:0];
		remw[0] = '0;
		unique case (alu_op_t'(opc[0]))
			OP_ADD:  accw[0] = aw[0] + bw[0];
			OP_SUB:  accw[0] = aw[0] + (~bw[0]) + N'(1);
			default: accw[0] = '0;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			alu_cell #(.WORD_BITS(N), .STEP(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.valid_in(vld[g]), .op_in(opc[g]), .a_in(aw[g]), .b_in(bw[g]),
				.acc_in(accw[g]), .rem_in(remw[g]),
				.valid_out(vld[g+1]), .op_out(opc[g+1]), .a_out(aw[g+1]),
				.b_out(bw[g+1]), .acc_out(accw[g+1]), .rem_out(remw[g+1])
			);
		end
	endgenerate

	// Divide by zero overrides the quotient.
	always_comb begin
		res_nxt = accw[N];
		dz_nxt  = 1'b0;
		if (alu_op_t'(opc[N]) == OP_DIV && bw[N] == '0) begin
			res_nxt = '1;
			dz_nxt  = 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q <= res_nxt;
			out_dz_q   <= dz_nxt;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = {out_word_q, out_dz_q};
endmodule

// File: hw/rtl/alu_checker.sv
// Port-level checker for the arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module alu_checker #(
	parameter int WORD_BITS = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [WORD_BITS:0]   out_data
);
	// A pending result holds while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Input is ready whenever the output is free or taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled without output backpressure");

	// A stall at the output stops the input.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

	// Flag only with an all-ones word.
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] |-> &out_data[WORD_BITS:1])
		else $error("divide by zero flag without all-ones result");
endmodule

bind alu_add_sub_mul_div_32 alu_checker #(.WORD_BITS(WORD_BITS)) u_alu_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data[WORD_BITS:0])
);

// File: tb/alu_add_sub_mul_div_32_tb.sv
// Testbench for the 32-bit add, subtract, multiply and divide unit.
`timescale 1ns / 1ps
module alu_add_sub_mul_div_32_tb;
	import alu_pkg::*;

	typedef struct packed {
		logic [31:0] result_word;
		logic        divide_by_zero;
	} alu_result_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   mismatch_count;
	int   result_count;
	int   item_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   op_seen [4];
	alu_result_t expected_results [$];

	alu_stream_if #(.PAYLOAD_BITS(66)) in_ch ();
	alu_stream_if #(.PAYLOAD_BITS(33)) out_ch ();

	alu_add_sub_mul_div_32 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("alu_add_sub_mul_div_32_tb failed");
				$finish;
			end
		end
	end

	// Computes the unit's result word and divide-by-zero flag for one item.
	function automatic alu_result_t compute_alu(alu_op_t op, logic [31:0] a, logic [31:0] b);
		alu_result_t r;
		logic [31:0] acc;
		logic [31:0] shifted;
		logic [32:0] rem;
		logic [31:0] quo;
		r.divide_by_zero = 1'b0;
		case (op)
			OP_ADD: r.result_word = a + b;
			OP_SUB: r.result_word = a + (~b) + 32'd1;
			OP_MUL: begin
				acc = '0;
				shifted = a;
				for (int i = 0; i < 32; i++) begin
					if (b[i]) acc = acc + shifted;
					shifted = shifted << 1;
				end
				r.result_word = acc;
			end
			default: begin
				if (b == 32'd0) begin
					r.result_word = '1;
					r.divide_by_zero = 1'b1;
				end else begin
					// Restoring division with a 33-bit partial remainder.
					rem = '0;
					quo = '0;
					for (int i = 31; i >= 0; i--) begin
						rem = {rem[31:0], a[i]};
						if (rem >= {1'b0, b}) begin
							rem = rem - {1'b0, b};
							quo[i] = 1'b1;
						end
					end
					r.result_word = quo;
				end
			end
		endcase
		return r;
	endfunction

	// Receiver: random stalls and comparison against the oldest expectation.
	initial begin
		alu_result_t got;
		alu_result_t want;
		out_ch.ready <= 1'b0;
		mismatch_count = 0;
		result_count = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				result_count++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got.result_word !== want.result_word ||
						got.divide_by_zero !== want.divide_by_zero) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected word %h dz %b, got word %h dz %b",
								want.result_word, want.divide_by_zero,
								got.result_word, got.divide_by_zero);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sends one item, idling at random beforehand, and records its expectation.
	// Valid stays high after acceptance so that back-to-back items need only
	// one assignment per edge; an idle cycle or the drain wait lowers it.
	task automatic send_item(alu_op_t op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {op, a, b};
		expected_results.push_back(compute_alu(op, a, b));
		op_seen[op]++;
		item_count++;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Random word biased toward extremes and small values.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom_range(15);
			1: return 32'hFFFF_FFFF - $urandom_range(15);
			2: return 32'h8000_0000 ^ $urandom_range(3);
			3: return $urandom() >> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// Extremes of every operation, including divide by zero.
	task automatic test_directed();
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'd1);
		send_item(OP_ADD, 32'h0, 32'h0);
		send_item(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_SUB, 32'h0, 32'd1);
		send_item(OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_MUL, 32'd3, 32'hFFFF_FFFE);
		send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 32'h1234_5678, 32'h0);
		send_item(OP_DIV, 32'd100, 32'd0);
		send_item(OP_DIV, 32'h0, 32'h0);
		send_item(OP_DIV, 32'hFFFF_FFFF, 32'd1);
		send_item(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_DIV, 32'd5, 32'h8000_0000);
		send_item(OP_DIV, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_item(OP_DIV, 32'h8000_0000, 32'd2);
		send_item(OP_DIV, 32'd7, 32'd3);
	endtask

	// Random items of every operation.
	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_item(alu_op_t'($urandom_range(3)), rand_word(), rand_word());
	endtask

	// Holds the sender until every expected result has arrived.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		item_count = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		send_idle_pct = 31;
		recv_idle_pct = 56;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(260);
		wait_drained();
		send_idle_pct = 56;
		recv_idle_pct = 31;
		test_random(280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(290);
		wait_drained();
		repeat (40) @(posedge clk);
		$display("sent %0d items (add %0d, sub %0d, mul %0d, div %0d), checked %0d results",
			item_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], result_count);
		$display("idle patterns covered: sender-heavy, receiver-heavy and back-to-back");
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("alu_add_sub_mul_div_32_tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				expected_results.size());
			$display("alu_add_sub_mul_div_32_tb failed");
		end
		$finish;
	end
endmodule

// File: files.f
hw/rtl/alu_pkg.sv
hw/rtl/alu_stream_if.sv
hw/rtl/alu_cell.sv
hw/rtl/alu_add_sub_mul_div_32.sv
hw/rtl/alu_checker.sv
tb/alu_add_sub_mul_div_32_tb.sv
